// ===== rtl/core/bbd_pkg.sv =====
package bbd_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 13;
    localparam int ROW_W = 13;
    localparam int Y_W   = 12;

    localparam logic [CFG_W-1:0] WIDTH_AT_RESET  = 13'd420;
    localparam logic [CFG_W-1:0] HEIGHT_AT_RESET = 13'd288;
    localparam logic [CFG_W-1:0] MIN_SIZE        = 13'd2;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT    = 13'd4096;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_type_t;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

    // Truncated mean of the enabled samples among up to four.
    function automatic pixel_t mean4(input pixel_t a, input pixel_t b, input pixel_t c,
                                     input pixel_t d, input logic [3:0] en);
        logic [9:0]  sum;
        logic [2:0]  cnt;
        logic [19:0] prod;
        pixel_t      q;
        sum = (en[0] ? {2'b00, a} : 10'd0) + (en[1] ? {2'b00, b} : 10'd0)
            + (en[2] ? {2'b00, c} : 10'd0) + (en[3] ? {2'b00, d} : 10'd0);
        cnt = {2'b00, en[0]} + {2'b00, en[1]} + {2'b00, en[2]} + {2'b00, en[3]};
        prod = {10'd0, sum} * 20'd683;
        case (cnt)
            3'd1:    q = sum[7:0];
            3'd2:    q = sum[8:1];
            3'd3:    q = prod[18:11];
            3'd4:    q = sum[9:2];
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

// ===== rtl/core/bayer_bilinear_demosaic.sv =====
// Bilinear Bayer demosaic for a raster-order raw pixel stream.
// Input channel s_*: one item per raw sample. s_tdata carries the 8-bit sample and
// s_tuser the request kind (pixel or flush tick). Red sites sit at odd row / even
// column, blue sites at even row / odd column, and the rest are green.
// Output channel m_*: one RGB pixel per result item, m_tlast marks the last pixel
// of the frame. Output pixels trail the input by one row plus one pixel; after
// the last sample of a frame, frame_width + 1 flush items drain the final row.
// Flush items sent while the frame is still receiving pixels are dropped.
// The block accepts one item every cycle. Each accepted item passes two register
// stages: one reads the line store, the next builds the 3x3 neighborhood and the
// color means. When the receiver stalls, the output register holds and s_tready
// falls in the same cycle; no item is lost. Frame size registers are written
// through the cfg_* port; the user must write them only while the block is idle,
// which the block does not enforce; each write restarts the frame position.
// Reset loads 420 x 288 and restarts the frame position; line store contents
// stay undefined until written and are only used where a row was stored.
module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PIX_W-1:0]    s_tdata,   // raw_pixel
    input  logic                s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [3*PIX_W-1:0]  m_tdata,   // red, green, blue
    output logic                m_tlast,   // frame_end
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);

    logic [CFG_W-1:0] fw_reg, fh_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WW-1:0]    w, fw_ext;
    logic [ROW_W-1:0] h;

    logic             s_accept, adv;
    logic [CW-1:0]    c0;
    logic [ROW_W-1:0] r0;
    logic             in_active, drop, emit_a, done_a, do_shift, emit_b;
    logic [Y_W-1:0]   y0;
    logic [CW-1:0]    x0;
    pixel_t           v0;

    logic             s1_valid_reg, s1_shift_reg, s1_emit_reg;
    logic [Y_W-1:0]   s1_y_reg;
    logic [CW-1:0]    s1_x_reg, s1_addr_reg;
    pixel_t           s1_pix_reg;

    line_pair_t       line_mem [MAX_WIDTH];
    line_pair_t       rd_reg;
    logic             rd_en, wr_en;

    pixel_t           win_reg [3][2];
    pixel_t           nb [3][3];
    logic             up_ok, dn_ok, lf_ok, rt_ok, yodd, xodd, fend;
    pixel_t           m_cross, m_diag, m_horiz, m_vert, red, green, blue;

    logic                m_valid_reg, m_last_reg;
    logic [3*PIX_W-1:0]  m_data_reg;

    always_comb begin
        fw_ext = WW'(fw_reg);
        if (fw_ext < WW'(MIN_SIZE)) begin
            w = WW'(MIN_SIZE);
        end else if (fw_ext > W_MAX) begin
            w = W_MAX;
        end else begin
            w = fw_ext;
        end
        if (fh_reg < MIN_SIZE) begin
            h = MIN_SIZE;
        end else if (fh_reg > HEIGHT_LIMIT) begin
            h = HEIGHT_LIMIT;
        end else begin
            h = fh_reg;
        end
    end

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;

    always_comb begin
        if ((WW'(col_reg) >= w) || ({1'b0, row_reg} > ({1'b0, h} + 14'd1))) begin
            c0 = '0;
            r0 = '0;
        end else begin
            c0 = col_reg;
            r0 = row_reg;
        end
        in_active = r0 < h;
        drop      = in_active && (s_tuser == REQ_FLUSH);
        emit_a    = !drop && (c0 == '0) && (r0 >= ROW_W'(2));
        done_a    = !drop && (c0 == '0) && ({1'b0, r0} >= ({1'b0, h} + 14'd1));
        do_shift  = !drop && !done_a;
        emit_b    = do_shift && (c0 != '0) && (r0 != '0);
        y0        = emit_a ? Y_W'(r0 - ROW_W'(2)) : Y_W'(r0 - ROW_W'(1));
        x0        = emit_a ? CW'(w - WW'(1)) : CW'(c0 - CW'(1));
        v0        = in_active ? s_tdata : '0;
        col_next  = col_reg;
        row_next  = row_reg;
        if (done_a) begin
            col_next = '0;
            row_next = '0;
        end else if (do_shift) begin
            if ((WW'(c0) + WW'(1)) == w) begin
                col_next = '0;
                row_next = r0 + ROW_W'(1);
            end else begin
                col_next = c0 + CW'(1);
                row_next = r0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= WIDTH_AT_RESET;
            fh_reg  <= HEIGHT_AT_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign rd_en = s_accept && do_shift;
    assign wr_en = adv && s1_valid_reg && s1_shift_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[s1_addr_reg] <= '{upper: rd_reg.middle, middle: s1_pix_reg};
        end
        if (rd_en) begin
            rd_reg <= line_mem[c0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_accept && (do_shift || emit_a);
            m_valid_reg  <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_shift_reg <= do_shift;
            s1_emit_reg  <= emit_a || emit_b;
            s1_y_reg     <= y0;
            s1_x_reg     <= x0;
            s1_addr_reg  <= c0;
            s1_pix_reg   <= v0;
            m_data_reg   <= {blue, green, red};
            m_last_reg   <= fend;
        end
        if (wr_en) begin
            win_reg[0][0] <= win_reg[0][1];
            win_reg[1][0] <= win_reg[1][1];
            win_reg[2][0] <= win_reg[2][1];
            win_reg[0][1] <= rd_reg.upper;
            win_reg[1][1] <= rd_reg.middle;
            win_reg[2][1] <= s1_pix_reg;
        end
    end

    // The left and center columns come from the window, the right column from the
    // line store read and the incoming sample.
    always_comb begin
        nb[0][0] = win_reg[0][0];
        nb[1][0] = win_reg[1][0];
        nb[2][0] = win_reg[2][0];
        nb[0][1] = win_reg[0][1];
        nb[1][1] = win_reg[1][1];
        nb[2][1] = win_reg[2][1];
        nb[0][2] = rd_reg.upper;
        nb[1][2] = rd_reg.middle;
        nb[2][2] = s1_pix_reg;

        up_ok = s1_y_reg != '0;
        dn_ok = ({1'b0, s1_y_reg} + ROW_W'(1)) < h;
        lf_ok = s1_x_reg != '0;
        rt_ok = (WW'(s1_x_reg) + WW'(1)) < w;
        yodd  = s1_y_reg[0];
        xodd  = s1_x_reg[0];
        fend  = (({1'b0, s1_y_reg} + ROW_W'(1)) == h) && ((WW'(s1_x_reg) + WW'(1)) == w);

        m_cross = mean4(nb[0][1], nb[2][1], nb[1][0], nb[1][2], {rt_ok, lf_ok, dn_ok, up_ok});
        m_diag  = mean4(nb[0][0], nb[0][2], nb[2][0], nb[2][2],
                        {dn_ok & rt_ok, dn_ok & lf_ok, up_ok & rt_ok, up_ok & lf_ok});
        m_horiz = mean4(nb[1][0], nb[1][2], '0, '0, {2'b00, rt_ok, lf_ok});
        m_vert  = mean4(nb[0][1], nb[2][1], '0, '0, {2'b00, dn_ok, up_ok});

        if (yodd && !xodd) begin
            red   = nb[1][1];
            green = m_cross;
            blue  = m_diag;
        end else if (!yodd && xodd) begin
            blue  = nb[1][1];
            green = m_cross;
            red   = m_diag;
        end else if (yodd) begin
            green = nb[1][1];
            red   = m_horiz;
            blue  = m_vert;
        end else begin
            green = nb[1][1];
            red   = m_vert;
            blue  = m_horiz;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        (WW'(col_reg) < w) && ({1'b0, row_reg} <= ({1'b0, h} + 14'd1)))
        else $error("frame position left the frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && wr_en |-> c0 != s1_addr_reg)
        else $error("line store read and write hit the same column");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_emit_reg |-> ({1'b0, s1_y_reg} < h) && (WW'(s1_x_reg) < w))
        else $error("output pixel position outside the frame");
`endif

endmodule

// ===== sim/bayer_bilinear_demosaic_tb.sv =====
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_tb;
    import bbd_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int SETTLE_CYCLES = 4;
    localparam int EXTREME_ITEMS = 64;

    typedef struct packed {
        pixel_t red;
        pixel_t green;
        pixel_t blue;
        logic   frame_end;
    } rgb_px_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_NONE,
        ROW_TYPED,
        ROW_PREDICT
    } row_kind_t;

    typedef enum int {
        NB_CROSS,
        NB_DIAG,
        NB_HORZ,
        NB_VERT
    } nbr_shape_t;

    typedef struct packed {
        row_kind_t        kind;
        cfg_reg_t         reg_sel;
        logic [CFG_W-1:0] reg_val;
        req_type_t        req;
        pixel_t           pix;
        rgb_px_t          want;
    } dir_row_t;

    localparam rgb_px_t NO_PX = '0;

    // A 2x2 frame with hand-computed colors, then a 3x3 frame left to the predictor.
    localparam dir_row_t DIRECTED [28] = '{
        '{ROW_NONE,    REG_FRAME_WIDTH,  13'd0, REQ_FLUSH, 8'h00, NO_PX},
        '{ROW_NONE,    REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h00, NO_PX},
        '{ROW_NONE,    REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'hFF, NO_PX},
        '{ROW_CFG,     REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h00, NO_PX},
        '{ROW_CFG,     REG_FRAME_HEIGHT, 13'd1, REQ_PIXEL, 8'h00, NO_PX},
        '{ROW_NONE,    REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'hFF, NO_PX},
        '{ROW_NONE,    REG_FRAME_WIDTH,  13'd0, REQ_FLUSH, 8'hFF, NO_PX},
        '{ROW_NONE,    REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h00, NO_PX},
        '{ROW_NONE,    REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h80, NO_PX},
        '{ROW_TYPED,   REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h01, '{8'h80, 8'hFF, 8'h00, 1'b0}},
        '{ROW_TYPED,   REG_FRAME_WIDTH,  13'd0, REQ_FLUSH, 8'h00, '{8'h80, 8'h80, 8'h00, 1'b0}},
        '{ROW_TYPED,   REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h5A, '{8'h80, 8'h80, 8'h00, 1'b0}},
        '{ROW_TYPED,   REG_FRAME_WIDTH,  13'd0, REQ_FLUSH, 8'h00, '{8'h80, 8'h01, 8'h00, 1'b1}},
        '{ROW_CFG,     REG_FRAME_WIDTH,  13'd3, REQ_PIXEL, 8'h00, NO_PX},
        '{ROW_CFG,     REG_FRAME_HEIGHT, 13'd3, REQ_PIXEL, 8'h00, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'hFF, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h01, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'hFE, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h02, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'hFD, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h03, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'hFC, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h04, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'hFB, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_FLUSH, 8'h00, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_PIXEL, 8'h77, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_FLUSH, 8'h00, NO_PX},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  13'd0, REQ_FLUSH, 8'h00, NO_PX}
    };

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    pixel_t             s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [3*PIX_W-1:0] m_tdata;
    logic               m_tlast;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    bayer_bilinear_demosaic #(
        .MAX_WIDTH(MAX_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    logic [CFG_W-1:0] width_reg  = WIDTH_AT_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_AT_RESET;
    pixel_t           upper_mem  [MAX_W];
    pixel_t           middle_mem [MAX_W];
    pixel_t           win        [3][3] = '{default: '0};
    int               cur_row    = 0;
    int               cur_col    = 0;

    rgb_px_t          pending_rgb [$];
    int               src_idle   = 13;
    int               sink_idle  = 59;
    int               mismatches = 0;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v < MIN_SIZE) return int'(MIN_SIZE);
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic pixel_t neighbor_mean(input int ctr, input int y, input int x,
                                             input int w, input int h,
                                             input nbr_shape_t shape);
        int sum;
        int cnt;
        bit take;
        sum = 0;
        cnt = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                case (shape)
                    NB_CROSS: take = (dy == 0) != (dx == 0);
                    NB_DIAG:  take = (dy != 0) && (dx != 0);
                    NB_HORZ:  take = (dy == 0) && (dx != 0);
                    NB_VERT:  take = (dx == 0) && (dy != 0);
                    default:  take = 1'b0;
                endcase
                if ((dy < 0 && y == 0) || (dy > 0 && y + 1 >= h) ||
                    (dx < 0 && x == 0) || (dx > 0 && x + 1 >= w)) begin
                    take = 1'b0;
                end
                if (take) begin
                    sum += int'(win[1 + dy][ctr + dx]);
                    cnt++;
                end
            end
        end
        return (cnt == 0) ? pixel_t'(0) : pixel_t'(sum / cnt);
    endfunction

    function automatic rgb_px_t pixel_color(input int ctr, input int y, input int x,
                                            input int w, input int h);
        rgb_px_t px;
        bit      y_odd;
        bit      x_odd;
        y_odd = y[0];
        x_odd = x[0];
        px.frame_end = (y + 1 == h) && (x + 1 == w);
        if (y_odd && !x_odd) begin
            px.red   = win[1][ctr];
            px.green = neighbor_mean(ctr, y, x, w, h, NB_CROSS);
            px.blue  = neighbor_mean(ctr, y, x, w, h, NB_DIAG);
        end else if (!y_odd && x_odd) begin
            px.blue  = win[1][ctr];
            px.green = neighbor_mean(ctr, y, x, w, h, NB_CROSS);
            px.red   = neighbor_mean(ctr, y, x, w, h, NB_DIAG);
        end else begin
            px.green = win[1][ctr];
            if (y_odd) begin
                px.red  = neighbor_mean(ctr, y, x, w, h, NB_HORZ);
                px.blue = neighbor_mean(ctr, y, x, w, h, NB_VERT);
            end else begin
                px.red  = neighbor_mean(ctr, y, x, w, h, NB_VERT);
                px.blue = neighbor_mean(ctr, y, x, w, h, NB_HORZ);
            end
        end
        return px;
    endfunction

    // Advances the demosaic state by one accepted item; returns 1 when a pixel comes out.
    function automatic bit demosaic_step(input req_type_t kind, input pixel_t pix,
                                         output rgb_px_t px);
        int     w;
        int     h;
        int     r;
        int     c;
        bit     got;
        pixel_t smp;
        w   = clamp_dim(width_reg, MAX_W);
        h   = clamp_dim(height_reg, int'(HEIGHT_LIMIT));
        r   = cur_row;
        c   = cur_col;
        got = 1'b0;
        smp = pix;
        px  = '0;
        if (c >= w || r > h + 1) begin
            c = 0;
            r = 0;
        end
        if (r < h) begin
            if (kind != REQ_PIXEL) return 1'b0;
        end else begin
            smp = '0;
        end
        if (c == 0) begin
            if (r >= 2) begin
                px  = pixel_color(2, r - 2, w - 1, w, h);
                got = 1'b1;
            end
            if (r >= h + 1) begin
                cur_row = 0;
                cur_col = 0;
                return got;
            end
        end
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]     = upper_mem[c];
        win[1][2]     = middle_mem[c];
        win[2][2]     = smp;
        upper_mem[c]  = middle_mem[c];
        middle_mem[c] = smp;
        if (c >= 1 && r >= 1) begin
            px  = pixel_color(1, r - 1, c - 1, w, h);
            got = 1'b1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        cur_col = c;
        cur_row = r;
        return got;
    endfunction

    function automatic pixel_t rand_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size(input int hi);
        if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 1));
        return CFG_W'($urandom_range(2, hi));
    endfunction

    task automatic drive_item(input req_type_t kind, input pixel_t pix,
                              input row_kind_t mode, input rgb_px_t want);
        rgb_px_t px;
        bit      got;
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        got = demosaic_step(kind, pix, px);
        if (mode == ROW_TYPED) begin
            pending_rgb.push_back(want);
        end else if (mode == ROW_PREDICT && got) begin
            pending_rgb.push_back(px);
        end
    endtask

    task automatic wait_settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_rgb.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
        wait_settle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (sel == REG_FRAME_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val;
        end
        cur_row = 0;
        cur_col = 0;
    endtask

    // A frame may be cut short and restarted by a register write. A cap above zero
    // limits the number of pixels sent.
    task automatic random_frame(input bit may_break, input int cap);
        int w;
        int h;
        int total;
        int stop_at;
        w       = clamp_dim(width_reg, MAX_W);
        h       = clamp_dim(height_reg, int'(HEIGHT_LIMIT));
        total   = w * h;
        stop_at = total;
        if (may_break && $urandom_range(0, 9) == 0) stop_at = int'($urandom_range(1, total - 1));
        if (cap > 0 && stop_at > cap) stop_at = cap;
        for (int i = 0; i < stop_at; i++) begin
            if ($urandom_range(0, 9) == 0) drive_item(REQ_FLUSH, rand_pixel(), ROW_PREDICT, NO_PX);
            drive_item(REQ_PIXEL, rand_pixel(), ROW_PREDICT, NO_PX);
        end
        if (stop_at < total) begin
            write_reg(REG_FRAME_HEIGHT, height_reg);
        end else begin
            for (int i = 0; i <= w; i++) begin
                drive_item(($urandom_range(0, 2) == 0) ? REQ_PIXEL : REQ_FLUSH, rand_pixel(),
                           ROW_PREDICT, NO_PX);
            end
            if ($urandom_range(0, 4) == 0) drive_item(REQ_FLUSH, rand_pixel(), ROW_PREDICT, NO_PX);
        end
    endtask

    initial begin
        rgb_px_t got;
        rgb_px_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
                if (pending_rgb.size() == 0) begin
                    $display("%0t ns: unexpected pixel r=%02h g=%02h b=%02h last=%0b",
                             $time, got.red, got.green, got.blue, got.frame_end);
                    mismatches++;
                end else begin
                    want = pending_rgb.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t ns: red expected %02h, got %02h",
                                 $time, want.red, got.red);
                        mismatches++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t ns: green expected %02h, got %02h",
                                 $time, want.green, got.green);
                        mismatches++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t ns: blue expected %02h, got %02h",
                                 $time, want.blue, got.blue);
                        mismatches++;
                    end
                    if (got.frame_end !== want.frame_end) begin
                        $display("%0t ns: frame_end expected %0b, got %0b",
                                 $time, want.frame_end, got.frame_end);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
            end else begin
                drive_item(DIRECTED[i].req, DIRECTED[i].pix, DIRECTED[i].kind,
                           DIRECTED[i].want);
            end
        end
        for (int mode = 0; mode < 3; mode++) begin
            src_idle  = (mode == 0) ? 13 : (mode == 1) ? 59 : 0;
            sink_idle = (mode == 0) ? 59 : (mode == 1) ? 13 : 0;
            repeat (4) begin
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(REG_FRAME_WIDTH, pick_size(12));
                    write_reg(REG_FRAME_HEIGHT, pick_size(5));
                end
                random_frame(1'b1, 0);
            end
        end
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, MIN_SIZE);
        random_frame(1'b0, EXTREME_ITEMS);
        write_reg(REG_FRAME_WIDTH, MIN_SIZE);
        write_reg(REG_FRAME_HEIGHT, 13'd5000);
        random_frame(1'b0, EXTREME_ITEMS);
        wait_settle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
